### src/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// Shared constants for the easing curve evaluator: fixed-point format,
// working width, easing mode codes, register indexes and curve constants.
// ----------------------------------------------------------------------------
package ece_pkg;

    // Fixed-point format: fraction bits and the working width of the datapath
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 28;
    localparam int RES_W     = DATA_W + 4;

    // Field widths
    localparam int PROG_W    = 18;
    localparam int EASE_W    = 19;
    localparam int CX_W      = 17;
    localparam int CY_W      = 19;
    localparam int MODE_W    = 4;
    localparam int IDX_W     = 3;
    localparam int WDATA_W   = 19;

    // Unity, half and the back-out constants
    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint C1_L   = (170158 * ONE_L + 50000) / 100000;
    localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(ONE_L);
    localparam logic signed [DATA_W-1:0] HALF_Q = DATA_W'(ONE_L / 2);
    localparam logic signed [DATA_W-1:0] C1_Q   = DATA_W'(C1_L);
    localparam logic signed [DATA_W-1:0] C3_Q   = DATA_W'(C1_L + ONE_L);

    // Output saturation bounds
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(262143);
    localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(262144);

    // Easing mode codes
    localparam logic [MODE_W-1:0] MODE_LINEAR      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BEZIER      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_IN_CUBIC    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_OUT_CUBIC   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_IN_QUAD     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_OUT_QUAD    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_INOUT_QUAD  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_IN_QUART    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OUT_QUART   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_INOUT_QUART = 4'd9;
    localparam logic [MODE_W-1:0] MODE_BACK_OUT    = 4'd10;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_EASING_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_CTRL_X1     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CTRL_Y1     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CTRL_X2     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CTRL_Y2     = 3'd4;

endpackage

### src/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Maps one progress value to an eased progress value for a configured curve.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q1.16 progress value per transfer; m_* returns one
//   signed Q2.16 eased value per accepted item, in order. The user must write
//   registers through cfg_we / cfg_index / cfg_wdata only while the block is
//   idle; the block does not enforce this. An index beyond the list is ignored.
//   All arithmetic runs through one shared multiplier and one restoring
//   divider (one quotient bit a cycle), steered by the sequencer below.
//   s_tready is high only while the sequencer is idle. The result sits in
//   an output register; a new item may be taken while it waits, and the
//   sequencer holds in its final state until the register is free. Reset
//   returns the registers to their defaults and empties the output register.
// ----------------------------------------------------------------------------
module easing_curve_evaluator #(
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [ece_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ece_pkg::WDATA_W-1:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] progress, [23:18] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [18:0] eased_value, [23:19] zero
);

    localparam int W       = ece_pkg::DATA_W;
    localparam int F       = ece_pkg::FRAC_BITS;
    localparam int RW      = ece_pkg::RES_W;
    localparam int MAXS    = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
    localparam int CNT_W   = $clog2(MAXS + 1);
    localparam int DIV_W   = W + F;
    localparam int DCNT_W  = $clog2(DIV_W);

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_MWAIT,
        ST_P0, ST_P1, ST_P2, ST_P3,
        ST_PW1, ST_PW2, ST_PW3, ST_BK1, ST_BK2,
        ST_NT0, ST_NT1, ST_NT2, ST_DIV, ST_NT3,
        ST_BIS, ST_BI0, ST_BI1, ST_Y0, ST_Y1, ST_FIN
    } state_t;

    typedef logic signed [W-1:0] word_t;

    // configuration registers
    logic [ece_pkg::MODE_W-1:0] easing_mode_reg;
    logic [ece_pkg::CX_W-1:0]   ctrl_x1_reg, ctrl_x2_reg;
    logic signed [ece_pkg::CY_W-1:0] ctrl_y1_reg, ctrl_y2_reg;

    // control
    state_t state_reg, state_next, mul_ret_reg, mul_ret_next, poly_ret_reg, poly_ret_next;
    logic   m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    // payload
    logic [F:0] tq_reg, tq_next, t_reg, t_next, lo_reg, lo_next, hi_reg, hi_next;
    word_t mul_a_reg, mul_a_next, mul_b_reg, mul_b_next, prod_reg;
    word_t base_reg, base_next;
    word_t p2_reg, p2_next, p3_reg, p3_next, p4_reg, p4_next;
    word_t acc_reg, acc_next, bk_reg, bk_next, res_reg, res_next, err_reg, err_next;
    word_t k2_reg, k2_next, k1_reg, k1_next, k0_reg, k0_next;
    logic  final_reg, final_next, neg_reg, neg_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next, rem_reg, rem_next;
    logic [ece_pkg::EASE_W-1:0] out_reg, out_next;

    // shared multiplier with round-half-up rescale
    logic signed [2*W-1:0] prod_full, prod_rnd;
    assign prod_full = (2*W)'(mul_a_reg) * (2*W)'(mul_b_reg);
    assign prod_rnd  = (prod_full + (2*W)'(longint'(1) << (F - 1))) >>> F;

    // clamp the incoming progress to zero..one
    logic signed [ece_pkg::PROG_W-1:0] prog_in;
    logic [F:0] prog_clamped;
    assign prog_in = $signed(s_tdata[ece_pkg::PROG_W-1:0]);
    always_comb begin
        if (prog_in < 0) begin
            prog_clamped = '0;
        end else if (prog_in > ece_pkg::PROG_W'(ece_pkg::ONE_L)) begin
            prog_clamped = (F+1)'(ece_pkg::ONE_L);
        end else begin
            prog_clamped = prog_in[F:0];
        end
    end

    // bezier coefficients from the control points
    word_t x1c, x2c, y1s, y2s, ax, bx, cx, ay, by, cy;
    always_comb begin
        x1c = (ctrl_x1_reg > ece_pkg::CX_W'(ece_pkg::ONE_L)) ? ece_pkg::ONE_Q
                                                             : W'(ctrl_x1_reg);
        x2c = (ctrl_x2_reg > ece_pkg::CX_W'(ece_pkg::ONE_L)) ? ece_pkg::ONE_Q
                                                             : W'(ctrl_x2_reg);
        y1s = W'(ctrl_y1_reg);
        y2s = W'(ctrl_y2_reg);
        cx  = W'(3) * x1c;
        bx  = W'(3) * (x2c - x1c) - cx;
        ax  = ece_pkg::ONE_Q - cx - bx;
        cy  = W'(3) * y1s;
        by  = W'(3) * (y2s - y1s) - cy;
        ay  = ece_pkg::ONE_Q - cy - by;
    end

    // mode decode
    word_t tq_s, t_s;
    logic  low_half, need3, need4;
    assign tq_s     = $signed(W'(tq_reg));
    assign t_s      = $signed(W'(t_reg));
    assign low_half = tq_s < ece_pkg::HALF_Q;
    always_comb begin
        need3 = !(easing_mode_reg inside {ece_pkg::MODE_IN_QUAD, ece_pkg::MODE_OUT_QUAD,
                                          ece_pkg::MODE_INOUT_QUAD});
        need4 = easing_mode_reg inside {ece_pkg::MODE_IN_QUART, ece_pkg::MODE_OUT_QUART,
                                        ece_pkg::MODE_INOUT_QUART};
    end

    // divider step
    logic [W:0]   rem_sh;
    logic         q_bit;
    logic [W-1:0] abs_err, abs_res;
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign q_bit   = rem_sh >= {1'b0, dvs_reg};
    assign abs_err = err_reg[W-1] ? W'(-err_reg) : W'(err_reg);
    assign abs_res = res_reg[W-1] ? W'(-res_reg) : W'(res_reg);

    // Newton update: t - quotient, clamped to zero..one
    logic signed [DIV_W:0]   quot;
    logic signed [DIV_W+1:0] t_new;
    logic [F:0] t_new_c;
    always_comb begin
        quot  = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        t_new = $signed({{(DIV_W+1-F){1'b0}}, t_reg}) - $signed({quot[DIV_W], quot});
        if (t_new < 0) begin
            t_new_c = '0;
        end else if (t_new > (DIV_W+2)'(ece_pkg::ONE_L)) begin
            t_new_c = (F+1)'(ece_pkg::ONE_L);
        end else begin
            t_new_c = t_new[F:0];
        end
    end

    // bisection update
    word_t cur;
    logic [F:0] lo_b, hi_b;
    logic [F+1:0] mid_sum;
    always_comb begin
        cur     = res_reg;
        lo_b    = (cur < tq_s) ? t_reg : lo_reg;
        hi_b    = (cur < tq_s) ? hi_reg : t_reg;
        mid_sum = {1'b0, lo_b} + {1'b0, hi_b};
    end

    // final result and saturation
    logic signed [RW-1:0] r_wide, r_sat;
    always_comb begin
        case (easing_mode_reg)
            ece_pkg::MODE_LINEAR:     r_wide = RW'(tq_s);
            ece_pkg::MODE_BEZIER:     r_wide = RW'(acc_reg);
            ece_pkg::MODE_IN_CUBIC:   r_wide = RW'(p3_reg);
            ece_pkg::MODE_IN_QUAD:    r_wide = RW'(p2_reg);
            ece_pkg::MODE_OUT_QUAD:   r_wide = RW'(ece_pkg::ONE_Q) - RW'(p2_reg);
            ece_pkg::MODE_INOUT_QUAD: begin
                r_wide = low_half ? (RW'(p2_reg) <<< 1)
                                  : RW'(ece_pkg::ONE_Q) - ((RW'(p2_reg) + 1) >>> 1);
            end
            ece_pkg::MODE_IN_QUART:   r_wide = RW'(p4_reg);
            ece_pkg::MODE_OUT_QUART:  r_wide = RW'(ece_pkg::ONE_Q) - RW'(p4_reg);
            ece_pkg::MODE_INOUT_QUART: begin
                r_wide = low_half ? (RW'(p4_reg) <<< 3)
                                  : RW'(ece_pkg::ONE_Q) - ((RW'(p4_reg) + 1) >>> 1);
            end
            ece_pkg::MODE_BACK_OUT:   r_wide = RW'(ece_pkg::ONE_Q) + RW'(acc_reg);
            default:                  r_wide = RW'(ece_pkg::ONE_Q) - RW'(p3_reg);
        endcase
        if (r_wide > ece_pkg::OUT_MAX) begin
            r_sat = ece_pkg::OUT_MAX;
        end else if (r_wide < ece_pkg::OUT_MIN) begin
            r_sat = ece_pkg::OUT_MIN;
        end else begin
            r_sat = r_wide;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        mul_ret_next  = mul_ret_reg;
        poly_ret_next = poly_ret_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        iter_next     = iter_reg;
        dcnt_next     = dcnt_reg;
        tq_next  = tq_reg;   t_next  = t_reg;   lo_next = lo_reg;  hi_next = hi_reg;
        mul_a_next = mul_a_reg; mul_b_next = mul_b_reg; base_next = base_reg;
        p2_next  = p2_reg;   p3_next = p3_reg;  p4_next = p4_reg;
        acc_next = acc_reg;  bk_next = bk_reg;  res_next = res_reg; err_next = err_reg;
        k2_next  = k2_reg;   k1_next = k1_reg;  k0_next = k0_reg;
        final_next = final_reg; neg_next = neg_reg;
        dvd_next = dvd_reg;  dvs_next = dvs_reg; rem_next = rem_reg;
        out_next = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tq_next    = prog_clamped;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                case (easing_mode_reg)
                    ece_pkg::MODE_LINEAR: state_next = ST_FIN;
                    ece_pkg::MODE_BEZIER: begin
                        t_next     = tq_reg;
                        iter_next  = '0;
                        state_next = ST_NT0;
                    end
                    default: begin
                        // pick the base of the power chain
                        case (easing_mode_reg)
                            ece_pkg::MODE_IN_CUBIC, ece_pkg::MODE_IN_QUAD,
                            ece_pkg::MODE_IN_QUART: base_next = tq_s;
                            ece_pkg::MODE_INOUT_QUAD, ece_pkg::MODE_INOUT_QUART: begin
                                base_next = low_half ? tq_s
                                                     : (ece_pkg::ONE_Q <<< 1) - (tq_s <<< 1);
                            end
                            ece_pkg::MODE_BACK_OUT: base_next = tq_s - ece_pkg::ONE_Q;
                            default: base_next = ece_pkg::ONE_Q - tq_s;
                        endcase
                        mul_a_next   = base_next;
                        mul_b_next   = base_next;
                        mul_ret_next = ST_PW1;
                        state_next   = ST_MWAIT;
                    end
                endcase
            end
            ST_MWAIT: state_next = mul_ret_reg;
            // power chain
            ST_PW1: begin
                p2_next = prod_reg;
                if (need3) begin
                    mul_a_next = prod_reg; mul_b_next = base_reg;
                    mul_ret_next = ST_PW2; state_next = ST_MWAIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_PW2: begin
                p3_next = prod_reg;
                if (need4) begin
                    mul_a_next = prod_reg; mul_b_next = base_reg;
                    mul_ret_next = ST_PW3; state_next = ST_MWAIT;
                end else if (easing_mode_reg == ece_pkg::MODE_BACK_OUT) begin
                    mul_a_next = ece_pkg::C3_Q; mul_b_next = prod_reg;
                    mul_ret_next = ST_BK1; state_next = ST_MWAIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_PW3: begin
                p4_next    = prod_reg;
                state_next = ST_FIN;
            end
            ST_BK1: begin
                bk_next    = prod_reg;
                mul_a_next = ece_pkg::C1_Q; mul_b_next = p2_reg;
                mul_ret_next = ST_BK2; state_next = ST_MWAIT;
            end
            ST_BK2: begin
                acc_next   = bk_reg + prod_reg;
                state_next = ST_FIN;
            end
            // Horner evaluation at t: ((k2*t + k1)*t + k0) then *t if final
            ST_P0: begin
                mul_a_next = k2_reg; mul_b_next = t_s;
                mul_ret_next = ST_P1; state_next = ST_MWAIT;
            end
            ST_P1: begin
                mul_a_next = prod_reg + k1_reg; mul_b_next = t_s;
                mul_ret_next = ST_P2; state_next = ST_MWAIT;
            end
            ST_P2: begin
                if (final_reg) begin
                    mul_a_next = prod_reg + k0_reg; mul_b_next = t_s;
                    mul_ret_next = ST_P3; state_next = ST_MWAIT;
                end else begin
                    res_next   = prod_reg + k0_reg;
                    state_next = poly_ret_reg;
                end
            end
            ST_P3: begin
                res_next   = prod_reg;
                state_next = poly_ret_reg;
            end
            // Newton steps
            ST_NT0: begin
                k2_next = ax; k1_next = bx; k0_next = cx; final_next = 1'b1;
                poly_ret_next = ST_NT1; state_next = ST_P0;
            end
            ST_NT1: begin
                err_next = res_reg - tq_s;
                k2_next = W'(3) * ax; k1_next = bx <<< 1; k0_next = cx; final_next = 1'b0;
                poly_ret_next = ST_NT2; state_next = ST_P0;
            end
            ST_NT2: begin
                if (err_reg == '0 || res_reg == '0) begin
                    state_next = ST_BIS;
                end else begin
                    dvd_next   = {abs_err, {F{1'b0}}};
                    dvs_next   = abs_res;
                    neg_next   = err_reg[W-1] ^ res_reg[W-1];
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[W-1:0];
                dvd_next  = {dvd_reg[DIV_W-2:0], q_bit};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_W - 1)) begin
                    state_next = ST_NT3;
                end
            end
            ST_NT3: begin
                t_next    = t_new_c;
                iter_next = iter_reg + 1'b1;
                state_next = (iter_reg == CNT_W'(NEWTON_STEPS - 1)) ? ST_BIS : ST_NT0;
            end
            // bisection steps on zero..one
            ST_BIS: begin
                iter_next  = '0;
                lo_next    = '0;
                hi_next    = (F+1)'(ece_pkg::ONE_L);
                state_next = (BISECT_STEPS == 0) ? ST_Y0 : ST_BI0;
            end
            ST_BI0: begin
                k2_next = ax; k1_next = bx; k0_next = cx; final_next = 1'b1;
                poly_ret_next = ST_BI1; state_next = ST_P0;
            end
            ST_BI1: begin
                if (cur == tq_s) begin
                    state_next = ST_Y0;
                end else begin
                    lo_next   = lo_b;
                    hi_next   = hi_b;
                    t_next    = mid_sum[F+1:1];
                    iter_next = iter_reg + 1'b1;
                    state_next = (iter_reg == CNT_W'(BISECT_STEPS - 1)) ? ST_Y0 : ST_BI0;
                end
            end
            // y(t)
            ST_Y0: begin
                k2_next = ay; k1_next = by; k0_next = cy; final_next = 1'b1;
                poly_ret_next = ST_Y1; state_next = ST_P0;
            end
            ST_Y1: begin
                acc_next   = res_reg;
                state_next = ST_FIN;
            end
            // hold until the output register is free
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    out_next     = r_sat[ece_pkg::EASE_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state, registered outputs and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mul_ret_reg     <= ST_IDLE;
            poly_ret_reg    <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            out_reg         <= '0;
            iter_reg        <= '0;
            dcnt_reg        <= '0;
            easing_mode_reg <= ece_pkg::MODE_LINEAR;
            ctrl_x1_reg     <= '0;
            ctrl_y1_reg     <= '0;
            ctrl_x2_reg     <= ece_pkg::CX_W'(ece_pkg::ONE_L);
            ctrl_y2_reg     <= ece_pkg::CY_W'(ece_pkg::ONE_L);
        end else begin
            state_reg    <= state_next;
            mul_ret_reg  <= mul_ret_next;
            poly_ret_reg <= poly_ret_next;
            m_valid_reg  <= m_valid_next;
            out_reg      <= out_next;
            iter_reg     <= iter_next;
            dcnt_reg     <= dcnt_next;
            if (cfg_we) begin
                case (cfg_index)
                    ece_pkg::REG_EASING_MODE: easing_mode_reg <= cfg_wdata[ece_pkg::MODE_W-1:0];
                    ece_pkg::REG_CTRL_X1:     ctrl_x1_reg     <= cfg_wdata[ece_pkg::CX_W-1:0];
                    ece_pkg::REG_CTRL_Y1:     ctrl_y1_reg     <= $signed(cfg_wdata);
                    ece_pkg::REG_CTRL_X2:     ctrl_x2_reg     <= cfg_wdata[ece_pkg::CX_W-1:0];
                    ece_pkg::REG_CTRL_Y2:     ctrl_y2_reg     <= $signed(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        tq_reg   <= tq_next;   t_reg   <= t_next;   lo_reg  <= lo_next;  hi_reg <= hi_next;
        mul_a_reg <= mul_a_next; mul_b_reg <= mul_b_next; base_reg <= base_next;
        prod_reg <= prod_rnd[W-1:0];
        p2_reg   <= p2_next;   p3_reg  <= p3_next;  p4_reg  <= p4_next;
        acc_reg  <= acc_next;  bk_reg  <= bk_next;  res_reg <= res_next; err_reg <= err_next;
        k2_reg   <= k2_next;   k1_reg  <= k1_next;  k0_reg  <= k0_next;
        final_reg <= final_next; neg_reg <= neg_next;
        dvd_reg  <= dvd_next;  dvs_reg <= dvs_next; rem_reg <= rem_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24 - ece_pkg::EASE_W){1'b0}}, out_reg};

endmodule
